// ===== hw/rtl/rte_pkg.sv =====
// Shared types, constants and the arctangent table for the ZXY Euler angle block.
package rte_pkg;

	// Fixed-point constants: Q2.14 inputs, Q3.13 angles, Q30 CORDIC angle accumulator.
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int TABLE_LEN         = 24;
	localparam int ACC_W             = 34;
	localparam int ARG_W             = 17;
	localparam int SQRT_STEPS        = 16;
	localparam int RAD_W             = 29;
	localparam int ROOT_W            = 15;
	localparam logic signed [ACC_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [16:0]      PI_Q13      = 17'sd25736;
	localparam logic signed [16:0]      HALF_PI_Q13 = 17'sd12868;
	localparam logic signed [15:0]      ONE_Q14     = 16'sd16384;

	// Lock case codes.
	localparam logic [1:0] LOCK_NONE = 2'd0;
	localparam logic [1:0] LOCK_NEG  = 2'd1;
	localparam logic [1:0] LOCK_POS  = 2'd2;

	// One input transaction: seven matrix entries.
	typedef struct packed {
		logic signed [15:0] r00;
		logic signed [15:0] r01;
		logic signed [15:0] r02;
		logic signed [15:0] r11;
		logic signed [15:0] r20;
		logic signed [15:0] r21;
		logic signed [15:0] r22;
	} mat_t;

	// One result transaction.
	typedef struct packed {
		logic signed [14:0] angle_x;
		logic signed [15:0] angle_y;
		logic signed [15:0] angle_z;
		logic [1:0]         lock_case;
	} ang_t;

	// Data that travels beside the square root pipeline.
	typedef struct packed {
		logic [1:0]             lock;
		logic signed [ARG_W-1:0] zy;
		logic signed [ARG_W-1:0] zx;
		logic signed [ARG_W-1:0] yy;
		logic signed [ARG_W-1:0] yx;
		logic signed [ARG_W-1:0] xy;
	} side_t;

	// Arctangent of 2^-i in Q30.
	function automatic logic signed [ACC_W-1:0] atan_q30(input int i);
		logic signed [ACC_W-1:0] v;
		case (i)
			0:  v = 34'sh3243F6A8;
			1:  v = 34'sh1DAC6705;
			2:  v = 34'sh0FADBAFC;
			3:  v = 34'sh07F56EA6;
			4:  v = 34'sh03FEAB76;
			5:  v = 34'sh01FFD55B;
			6:  v = 34'sh00FFFAAA;
			7:  v = 34'sh007FFF55;
			8:  v = 34'sh003FFFEA;
			9:  v = 34'sh001FFFFD;
			10: v = 34'sh000FFFFF;
			11: v = 34'sh0007FFFF;
			12: v = 34'sh0003FFFF;
			13: v = 34'sh0001FFFF;
			14: v = 34'sh0000FFFF;
			15: v = 34'sh00007FFF;
			16: v = 34'sh00003FFF;
			17: v = 34'sh00001FFF;
			18: v = 34'sh00000FFF;
			19: v = 34'sh000007FF;
			20: v = 34'sh000003FF;
			21: v = 34'sh000001FF;
			22: v = 34'sh000000FF;
			23: v = 34'sh0000007F;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== hw/rtl/rotation_to_euler_zxy.sv =====
// Top level: ZXY Euler angles from a Q2.14 rotation matrix through pipelined CORDIC.
//
// Usage: drive the seven matrix entries on mat and raise start for one cycle per
// transaction. busy is always low, so a new transaction is taken every cycle.
// Each result appears on res for exactly one cycle with done high; the receiver
// cannot stall it and must take it in that cycle.
// A transaction passes through the input register, the squaring multiplier,
// the 16-step square root, the CORDIC (one stage per iteration plus folding
// and rounding) and the output register. Throughput is one transaction per
// cycle.
// Gimbal lock (r21 at or beyond plus or minus one) gives x = +/- pi/2, y = 0 and
// z from r02, r00; lock_case reports which case applied.
// Reset clears every valid bit; no result is produced until new transactions
// arrive, and nothing needs to be written before use.
module rotation_to_euler_zxy #(
	parameter int CORDIC_STAGES = rte_pkg::CORDIC_STAGES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  rte_pkg::mat_t mat,
	output logic          done,
	output rte_pkg::ang_t res
);
	import rte_pkg::*;

	localparam int CORDIC_LAT = CORDIC_STAGES + 2;

	mat_t                    mat_s1;
	logic                    vld_s1;
	logic [RAD_W-1:0]        rad_s2;
	side_t                   side_s2;
	logic                    vld_s2;
	logic signed [31:0]      sq;
	logic [31:0]             rad_full;
	side_t                   side_c;
	logic                    sq_vld;
	logic [ROOT_W-1:0]       root;
	side_t                   side_sq;
	logic                    vx_out, vy_out, vz_out;
	logic signed [15:0]      ang_x, ang_y, ang_z;
	logic [1:0]              lock_d [0:CORDIC_LAT];
	ang_t                    res_c;
	ang_t                    res_q;
	logic                    done_q;

	assign busy = 1'b0;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		mat_s1 <= mat;
	end

	// Case decode, CORDIC operand selection and the squared sine.
	always_comb begin
		sq       = mat_s1.r21 * mat_s1.r21;
		rad_full = 32'd1 << 28;
		rad_full = rad_full - 32'(sq);
		if (mat_s1.r21 >= ONE_Q14) begin
			side_c.lock = LOCK_POS;
		end else if (mat_s1.r21 <= -ONE_Q14) begin
			side_c.lock = LOCK_NEG;
		end else begin
			side_c.lock = LOCK_NONE;
		end
		if (side_c.lock == LOCK_NONE) begin
			side_c.zy = -ARG_W'(mat_s1.r01);
			side_c.zx = ARG_W'(mat_s1.r11);
		end else begin
			side_c.zy = ARG_W'(mat_s1.r02);
			side_c.zx = ARG_W'(mat_s1.r00);
		end
		side_c.yy = -ARG_W'(mat_s1.r20);
		side_c.yx = ARG_W'(mat_s1.r22);
		side_c.xy = ARG_W'(mat_s1.r21);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		rad_s2  <= rad_full[RAD_W-1:0];
		side_s2 <= side_c;
	end

	// Cosine of the X angle.
	rte_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s2),
		.rad      (rad_s2),
		.side_in  (side_s2),
		.out_vld  (sq_vld),
		.root     (root),
		.side_out (side_sq)
	);

	// Three arctangents in parallel.
	rte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (sq_vld),
		.y_in    (side_sq.xy),
		.x_in    (ARG_W'({1'b0, root})),
		.out_vld (vx_out),
		.angle   (ang_x)
	);

	rte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (sq_vld),
		.y_in    (side_sq.yy),
		.x_in    (side_sq.yx),
		.out_vld (vy_out),
		.angle   (ang_y)
	);

	rte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_z (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (sq_vld),
		.y_in    (side_sq.zy),
		.x_in    (side_sq.zx),
		.out_vld (vz_out),
		.angle   (ang_z)
	);

	// Lock case rides beside the CORDIC pipelines.
	assign lock_d[0] = side_sq.lock;
	for (genvar d = 0; d < CORDIC_LAT; d++) begin : g_lock
		always_ff @(posedge clk) begin
			lock_d[d+1] <= lock_d[d];
		end
	end

	// Final selection by case.
	always_comb begin
		res_c.lock_case = lock_d[CORDIC_LAT];
		case (lock_d[CORDIC_LAT])
			LOCK_POS: begin
				res_c.angle_x = 15'(HALF_PI_Q13);
				res_c.angle_y = '0;
				res_c.angle_z = ang_z;
			end
			LOCK_NEG: begin
				res_c.angle_x = -15'(HALF_PI_Q13);
				res_c.angle_y = '0;
				res_c.angle_z = -ang_z;
			end
			default: begin
				if (ang_x > 16'(HALF_PI_Q13)) begin
					res_c.angle_x = 15'(HALF_PI_Q13);
				end else if (ang_x < -16'(HALF_PI_Q13)) begin
					res_c.angle_x = -15'(HALF_PI_Q13);
				end else begin
					res_c.angle_x = ang_x[14:0];
				end
				res_c.angle_y = ang_y;
				res_c.angle_z = ang_z;
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vx_out;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_c;
	end

	assign done = done_q;
	assign res  = res_q;

	// The three arctangent pipelines stay in step.
	a_cordic_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(vx_out == vy_out) && (vx_out == vz_out))
		else $error("CORDIC pipelines out of step");

	// A lock result never carries a Y angle.
	a_lock_y_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (res.lock_case != LOCK_NONE) |-> res.angle_y == '0)
		else $error("Y angle nonzero in gimbal lock");

	// The X angle never leaves plus or minus pi/2.
	a_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (res.angle_x <= 15'(HALF_PI_Q13)) && (res.angle_x >= -15'(HALF_PI_Q13)))
		else $error("X angle out of range");

	// A transaction in the squaring register reaches done after the sqrt and CORDIC pipelines.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> ##(SQRT_STEPS + CORDIC_LAT + 1) done)
		else $error("Result missing after pipeline latency");

endmodule

// ===== hw/rtl/rte_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, with side data.
module rte_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_vld,
	input  logic [rte_pkg::RAD_W-1:0]  rad,
	input  rte_pkg::side_t             side_in,
	output logic                       out_vld,
	output logic [rte_pkg::ROOT_W-1:0] root,
	output rte_pkg::side_t             side_out
);
	import rte_pkg::*;

	logic [RAD_W-1:0] rem_s  [0:SQRT_STEPS];
	logic [31:0]      root_s [0:SQRT_STEPS];
	logic             vld_s  [0:SQRT_STEPS];
	side_t            side_s [0:SQRT_STEPS];

	// Stage zero is the incoming transaction.
	always_comb begin
		rem_s[0]  = rad;
		root_s[0] = '0;
		vld_s[0]  = in_vld;
		side_s[0] = side_in;
	end

	// Each stage tries one bit of the root against the running remainder.
	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam logic [31:0] BIT = 32'd1 << (30 - 2 * k);
		logic [32:0] trial;
		assign trial = {1'b0, root_s[k]} + {1'b0, BIT};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			side_s[k+1] <= side_s[k];
			if ({4'd0, rem_s[k]} >= trial) begin
				rem_s[k+1]  <= rem_s[k] - trial[RAD_W-1:0];
				root_s[k+1] <= (root_s[k] >> 1) + BIT;
			end else begin
				rem_s[k+1]  <= rem_s[k];
				root_s[k+1] <= root_s[k] >> 1;
			end
		end
	end

	assign out_vld  = vld_s[SQRT_STEPS];
	assign root     = root_s[SQRT_STEPS][ROOT_W-1:0];
	assign side_out = side_s[SQRT_STEPS];

endmodule

// ===== hw/rtl/rte_cordic.sv =====
// Pipelined vectoring CORDIC that returns atan2(y, x) in Q3.13 radians.
module rte_cordic #(
	parameter int STAGES = rte_pkg::CORDIC_STAGES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_vld,
	input  logic signed [rte_pkg::ARG_W-1:0] y_in,
	input  logic signed [rte_pkg::ARG_W-1:0] x_in,
	output logic                             out_vld,
	output logic signed [15:0]               angle
);
	import rte_pkg::*;

	logic signed [ACC_W-1:0] x_s [0:STAGES];
	logic signed [ACC_W-1:0] y_s [0:STAGES];
	logic signed [ACC_W-1:0] a_s [0:STAGES];
	logic                    z_s [0:STAGES];
	logic                    v_s [0:STAGES];

	logic signed [ACC_W-1:0] vx0, vy0, px, py, pa;
	logic signed [ACC_W-1:0] rsum, rq;
	logic signed [15:0]      ang_c;
	logic signed [15:0]      angle_q;
	logic                    vld_q;

	// Scale to Q28 and fold the left half plane into the right.
	always_comb begin
		vx0 = ACC_W'(x_in) <<< 14;
		vy0 = ACC_W'(y_in) <<< 14;
		px  = vx0;
		py  = vy0;
		pa  = '0;
		if (vx0 < 0) begin
			if (vy0 >= 0) begin
				px = vy0;
				py = -vx0;
				pa = HALF_PI_Q30;
			end else begin
				px = -vy0;
				py = vx0;
				pa = -HALF_PI_Q30;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		x_s[0] <= px;
		y_s[0] <= py;
		a_s[0] <= pa;
		z_s[0] <= (x_in == '0) && (y_in == '0);
	end

	// One micro-rotation per stage; stages past the table only pass data on.
	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			z_s[i+1] <= z_s[i];
			if (i >= TABLE_LEN) begin
				x_s[i+1] <= x_s[i];
				y_s[i+1] <= y_s[i];
				a_s[i+1] <= a_s[i];
			end else if (y_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				a_s[i+1] <= a_s[i] + atan_q30(i);
			end else begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				a_s[i+1] <= a_s[i] - atan_q30(i);
			end
		end
	end

	// Round to Q3.13, clamp to plus or minus pi, and give zero for a zero vector.
	always_comb begin
		rsum = a_s[STAGES] + ACC_W'(65536);
		rq   = rsum >>> 17;
		if (z_s[STAGES]) begin
			ang_c = '0;
		end else if (rq > ACC_W'(PI_Q13)) begin
			ang_c = 16'(PI_Q13);
		end else if (rq < -ACC_W'(PI_Q13)) begin
			ang_c = -16'(PI_Q13);
		end else begin
			ang_c = rq[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= v_s[STAGES];
		end
	end

	always_ff @(posedge clk) begin
		angle_q <= ang_c;
	end

	assign out_vld = vld_q;
	assign angle   = angle_q;

endmodule

// ===== dv/rotation_to_euler_zxy_tb.sv =====
// Testbench for the ZXY Euler angle block: directed and random matrices checked against a predictor.
`timescale 1ns / 100ps

module rotation_to_euler_zxy_tb;
	import rte_pkg::*;

	localparam int STAGES = CORDIC_STAGES_DEF;
	localparam int LATENCY = STAGES + 21;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	mat_t mat = '0;
	ang_t res;

	ang_t angles_due[$];
	int errors = 0;
	longint cycles = 0;

	rotation_to_euler_zxy #(.CORDIC_STAGES(STAGES)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.mat(mat), .done(done), .res(res)
	);

	always #5 clk = ~clk;

	// Arctangent table in Q30.
	function automatic longint atan_step(int i);
		longint t[24] = '{
			64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
			64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
			64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
			64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
			64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
			64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
		return t[i];
	endfunction

	function automatic int clip(int v, int lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	// Vectoring CORDIC arctangent, Q2.14 arguments to Q3.13 radians.
	function automatic int vector_angle(int y, int x);
		longint vx, vy, ang, dx, dy, t;
		vx = longint'(x) * 16384;
		vy = longint'(y) * 16384;
		ang = 0;
		if (x == 0 && y == 0) return 0;
		if (vx < 0) begin
			t = vx;
			if (vy >= 0) begin
				vx = vy; vy = -t; ang = 1686629713;
			end else begin
				vx = -vy; vy = t; ang = -1686629713;
			end
		end
		for (int i = 0; i < STAGES && i < 24; i++) begin
			dx = vy >>> i;
			dy = vx >>> i;
			if (vy >= 0) begin
				vx += dx; vy -= dy; ang += atan_step(i);
			end else begin
				vx -= dx; vy += dy; ang -= atan_step(i);
			end
		end
		return clip(int'((ang + 65536) >>> 17), 25736);
	endfunction

	// Integer square root, floor.
	function automatic int root_floor(longint n);
		longint r = 0;
		while ((r + 1) * (r + 1) <= n) r++;
		return int'(r);
	endfunction

	// Expected angles for one matrix.
	function automatic ang_t euler_of(mat_t m);
		ang_t a;
		int ax, ay, az, c;
		int r21 = m.r21;
		if (r21 >= 16384) begin
			ax = 12868; az = vector_angle(m.r02, m.r00); ay = 0;
			a.lock_case = LOCK_POS;
		end else if (r21 <= -16384) begin
			ax = -12868; az = -vector_angle(m.r02, m.r00); ay = 0;
			a.lock_case = LOCK_NEG;
		end else begin
			c = root_floor((longint'(1) << 28) - longint'(r21) * r21);
			ax = clip(vector_angle(r21, c), 12868);
			az = vector_angle(-int'(m.r01), m.r11);
			ay = vector_angle(-int'(m.r20), m.r22);
			a.lock_case = LOCK_NONE;
		end
		a.angle_x = ax[14:0];
		a.angle_y = ay[15:0];
		a.angle_z = az[15:0];
		return a;
	endfunction

	// Send one matrix, after a random gap when gaps is set; start stays high for a following transaction.
	task automatic send_matrix(mat_t m, bit gaps = 1);
		int gap = gaps ? $urandom_range(0, 10) : 0;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		mat <= m;
		@(posedge clk);
		while (busy) @(posedge clk);
		angles_due.push_back(euler_of(m));
		@(negedge clk);
	endtask

	// Close a burst of transactions.
	task automatic end_burst();
		start <= 1'b0;
		@(negedge clk);
	endtask

	function automatic mat_t any_matrix();
		mat_t m;
		logic [127:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom};
		m = raw[$bits(mat_t)-1:0];
		return m;
	endfunction

	task automatic test_directed();
		mat_t m;
		shortint ext[6] = '{-32768, 32767, 0, 16384, -16384, 1};
		for (int i = 0; i < 6; i++) begin
			m = '{ext[i], ext[i], ext[i], ext[i], ext[i], ext[i], ext[i]};
			send_matrix(m);
		end
		// Zero vectors in both lock cases and in the normal case.
		send_matrix('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0});
		send_matrix('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0});
		send_matrix('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
		// Boundaries of the lock cases.
		send_matrix('{16'sd100, 16'sd5, 16'sd200, 16'sd7, 16'sd3, 16'sd16383, -16'sd9});
		send_matrix('{-16'sd100, 16'sd5, -16'sd200, 16'sd7, 16'sd3, -16'sd16383, 16'sd9});
		send_matrix('{-16'sd100, 16'sd5, 16'sd200, 16'sd7, 16'sd3, 16'sd20000, 16'sd9});
		send_matrix('{-16'sd100, 16'sd5, -16'sd200, 16'sd7, 16'sd3, -16'sd20000, 16'sd9});
		// Identity and negative x arguments on both sides of the y axis.
		send_matrix('{16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384});
		send_matrix('{16'sd0, 16'sd300, 16'sd0, -16'sd16384, 16'sd300, 16'sd0, -16'sd16384});
		send_matrix('{16'sd0, -16'sd300, 16'sd0, -16'sd16384, -16'sd300, 16'sd0, -16'sd16384});
		end_burst();
	endtask

	task automatic test_random(int n, bit gaps);
		mat_t m;
		for (int i = 0; i < n; i++) begin
			m = any_matrix();
			// A quarter with r21 inside the unit range, a quarter in positive lock, the rest left random.
			case ($urandom_range(0, 3))
				0: m.r21 = 16'($signed($urandom_range(0, 32767)) - 16384);
				1: m.r21 = 16'($urandom_range(16384, 32767));
				default: ;
			endcase
			send_matrix(m, gaps);
		end
		end_burst();
	endtask

	// Wait until every expected result has been seen.
	task automatic drain();
		while (angles_due.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// Checker of each result transaction.
	always @(posedge clk) begin
		ang_t want;
		if (done) begin
			if (angles_due.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				want = angles_due.pop_front();
				if (res.angle_x !== want.angle_x) begin
					$error("angle_x expected %0d actual %0d", want.angle_x, res.angle_x);
					errors++;
				end
				if (res.angle_y !== want.angle_y) begin
					$error("angle_y expected %0d actual %0d", want.angle_y, res.angle_y);
					errors++;
				end
				if (res.angle_z !== want.angle_z) begin
					$error("angle_z expected %0d actual %0d", want.angle_z, res.angle_z);
					errors++;
				end
				if (res.lock_case !== want.lock_case) begin
					$error("lock_case expected %0d actual %0d", want.lock_case,
						res.lock_case);
					errors++;
				end
			end
		end
	end

	// Timeout watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** rotation_to_euler_zxy: FAILED **");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		// Hold off until the pipeline is empty.
		drain();
		test_random(900, 1);
		test_random(800, 0);
		drain();
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && angles_due.size() == 0)
			$display("** rotation_to_euler_zxy: PASSED **");
		else
			$display("** rotation_to_euler_zxy: FAILED **");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/rte_pkg.sv
hw/rtl/rte_sqrt.sv
hw/rtl/rte_cordic.sv
hw/rtl/rotation_to_euler_zxy.sv
dv/rotation_to_euler_zxy_tb.sv
